[design/mtt_pkg.sv]
// Shared types, character codes and helper functions for the markup tag tokenizer.
`timescale 1ns / 1ps

package mtt_pkg;

	// Parser states; codes above ST_AVAL are unused and behave as ST_OUT
	typedef enum logic [3:0] {
		ST_OUT     = 4'd0,
		ST_LEAD    = 4'd1,
		ST_TNAME   = 4'd2,
		ST_BANG1   = 4'd3,
		ST_BANG    = 4'd4,
		ST_COMMENT = 4'd5,
		ST_PLEAD   = 4'd6,
		ST_PNAME   = 4'd7,
		ST_APNAME  = 4'd8,
		ST_VLEAD   = 4'd9,
		ST_DQ      = 4'd10,
		ST_SQ      = 4'd11,
		ST_BARE    = 4'd12,
		ST_AVAL    = 4'd13
	} state_t;

	typedef enum logic [1:0] {
		CL_NONE  = 2'd0,
		CL_TAG   = 2'd1,
		CL_PNAME = 2'd2,
		CL_PVAL  = 2'd3
	} class_t;

	typedef enum logic [1:0] {
		PD_NONE    = 2'd0,
		PD_VALUE   = 2'd1,
		PD_NOVALUE = 2'd2
	} pdone_t;

	typedef enum logic [2:0] {
		TD_NONE  = 3'd0,
		TD_START = 3'd1,
		TD_END   = 3'd2,
		TD_ABORT = 3'd3,
		TD_SKIP  = 3'd4
	} tdone_t;

	localparam logic [7:0] CH_NUL   = 8'h00;
	localparam logic [7:0] CH_TAB   = 8'h09;
	localparam logic [7:0] CH_LF    = 8'h0A;
	localparam logic [7:0] CH_CR    = 8'h0D;
	localparam logic [7:0] CH_SP    = 8'h20;
	localparam logic [7:0] CH_BANG  = 8'h21;
	localparam logic [7:0] CH_DQ    = 8'h22;
	localparam logic [7:0] CH_SQ    = 8'h27;
	localparam logic [7:0] CH_DASH  = 8'h2D;
	localparam logic [7:0] CH_SLASH = 8'h2F;
	localparam logic [7:0] CH_LT    = 8'h3C;
	localparam logic [7:0] CH_EQ    = 8'h3D;
	localparam logic [7:0] CH_GT    = 8'h3E;
	localparam logic [7:0] CH_UC_A  = 8'h41;
	localparam logic [7:0] CH_UC_Z  = 8'h5A;
	localparam logic [7:0] CASE_GAP = 8'h20;

	typedef struct packed {
		logic [7:0] in_byte;
		logic       stream_end;
	} item_t;

	typedef struct packed {
		logic [7:0] out_byte;
		class_t     out_class;
		pdone_t     param_done;
		tdone_t     tag_done;
	} result_t;

	typedef struct packed {
		state_t st;
		logic   tag_is_end;
		logic   hyphen_seen;
	} parse_t;

	function automatic logic is_blank(input logic [7:0] c);
		return c inside {CH_SP, CH_TAB, CH_LF, CH_CR};
	endfunction

	function automatic logic [7:0] lower_ch(input logic [7:0] c);
		return (c inside {[CH_UC_A:CH_UC_Z]}) ? c + CASE_GAP : c;
	endfunction

endpackage

[design/mtt_stream_if.sv]
// Valid/ready channel interface carrying one packed item per handshake.
`timescale 1ns / 1ps

interface mtt_stream_if #(
	parameter type payload_t = logic
);
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

[design/mtt_step.sv]
// Next-state and result logic of the tokenizer for one byte.
`timescale 1ns / 1ps

module mtt_step
	import mtt_pkg::*;
(
	input  parse_t  cur,
	input  item_t   item,
	output parse_t  nxt,
	output result_t res
);

	logic [7:0] c;
	logic       skip;
	state_t     st;
	tdone_t     fin_tag;
	logic       is_end_q;
	parse_t     idle;

	assign c        = item.in_byte;
	assign skip     = is_blank(c) || (c == CH_NUL);
	assign st       = (cur.st > ST_AVAL) ? ST_OUT : cur.st;
	assign is_end_q = cur.tag_is_end;
	assign fin_tag  = is_end_q ? TD_END : TD_START;
	assign idle     = '{st: ST_OUT, tag_is_end: 1'b0, hyphen_seen: 1'b0};

	// next state
	always_comb begin
		nxt = '{st: st, tag_is_end: cur.tag_is_end, hyphen_seen: cur.hyphen_seen};
		if (item.stream_end) begin
			nxt = idle;
		end else begin
			case (st)
				ST_OUT: begin
					if (c == CH_LT) nxt = '{st: ST_LEAD, tag_is_end: 1'b0, hyphen_seen: 1'b0};
				end
				ST_LEAD: begin
					if (!skip) begin
						if (c == CH_SLASH) begin
							nxt.tag_is_end = 1'b1;
							nxt.st = ST_TNAME;
						end else if (c == CH_BANG) nxt.st = ST_BANG1;
						else if (c == CH_GT) nxt = idle;
						else nxt.st = ST_TNAME;
					end
				end
				ST_TNAME: begin
					if (c == CH_NUL || c == CH_GT) nxt = idle;
					else if (is_blank(c)) nxt.st = ST_PLEAD;
				end
				ST_BANG1: begin
					if (c == CH_DASH) begin
						nxt.hyphen_seen = 1'b0;
						nxt.st = ST_COMMENT;
					end else nxt.st = ST_BANG;
				end
				ST_BANG: begin
					if (c == CH_NUL || c == CH_GT) nxt = idle;
				end
				ST_COMMENT: begin
					if (!cur.hyphen_seen) nxt.hyphen_seen = (c == CH_DASH);
					else if (c == CH_GT) nxt = idle;
					else if (c != CH_DASH) nxt.hyphen_seen = 1'b0;
				end
				ST_PLEAD, ST_AVAL: begin
					if (!skip) begin
						if (c == CH_GT) nxt = idle;
						else if (c == CH_EQ) nxt.st = ST_VLEAD;
						else nxt.st = ST_PNAME;
					end
				end
				ST_PNAME: begin
					if (c == CH_NUL || c == CH_GT) nxt = idle;
					else if (c == CH_EQ) nxt.st = ST_VLEAD;
					else if (is_blank(c)) nxt.st = ST_APNAME;
				end
				ST_APNAME: begin
					if (!skip) begin
						if (c == CH_EQ) nxt.st = ST_VLEAD;
						else if (c == CH_GT) nxt = idle;
						else nxt.st = ST_PNAME;
					end
				end
				ST_VLEAD: begin
					if (!skip) begin
						if (c == CH_DQ) nxt.st = ST_DQ;
						else if (c == CH_SQ) nxt.st = ST_SQ;
						else if (c == CH_GT) nxt = idle;
						else nxt.st = ST_BARE;
					end
				end
				ST_DQ: begin
					if (c == CH_NUL) nxt = idle;
					else if (c == CH_DQ) nxt.st = ST_AVAL;
				end
				ST_SQ: begin
					if (c == CH_NUL) nxt = idle;
					else if (c == CH_SQ) nxt.st = ST_AVAL;
				end
				ST_BARE: begin
					if (c == CH_NUL || c == CH_GT) nxt = idle;
					else if (is_blank(c)) nxt.st = ST_AVAL;
				end
				default: nxt = idle;
			endcase
		end
	end

	// result
	always_comb begin
		res = '{out_byte: 8'h00, out_class: CL_NONE, param_done: PD_NONE, tag_done: TD_NONE};
		if (item.stream_end) begin
			if (st != ST_OUT) res.tag_done = TD_ABORT;
		end else begin
			case (st)
				ST_LEAD: begin
					if (!skip) begin
						if (c == CH_GT) res.tag_done = fin_tag;
						else if (c != CH_SLASH && c != CH_BANG) begin
							res.out_byte  = lower_ch(c);
							res.out_class = CL_TAG;
						end
					end
				end
				ST_TNAME: begin
					if (c == CH_NUL) res.tag_done = TD_ABORT;
					else if (c == CH_GT) res.tag_done = fin_tag;
					else if (!is_blank(c)) begin
						res.out_byte  = lower_ch(c);
						res.out_class = CL_TAG;
					end
				end
				ST_BANG: begin
					if (c == CH_NUL) res.tag_done = TD_ABORT;
					else if (c == CH_GT) res.tag_done = TD_SKIP;
				end
				ST_COMMENT: begin
					if (cur.hyphen_seen && c == CH_GT) res.tag_done = TD_SKIP;
				end
				ST_PLEAD, ST_APNAME, ST_AVAL: begin
					if (!skip && !(st == ST_APNAME && c == CH_EQ)) begin
						if (st == ST_APNAME) res.param_done = PD_NOVALUE;
						else if (st == ST_AVAL) res.param_done = PD_VALUE;
						if (c == CH_GT) res.tag_done = fin_tag;
						else if (c != CH_EQ) begin
							res.out_byte  = lower_ch(c);
							res.out_class = CL_PNAME;
						end
					end
				end
				ST_PNAME: begin
					if (c == CH_NUL) res.tag_done = TD_ABORT;
					else if (c == CH_GT) begin
						res.param_done = PD_NOVALUE;
						res.tag_done   = fin_tag;
					end else if (c != CH_EQ && !is_blank(c)) begin
						res.out_byte  = lower_ch(c);
						res.out_class = CL_PNAME;
					end
				end
				ST_VLEAD: begin
					if (!skip && c != CH_DQ && c != CH_SQ) begin
						if (c == CH_GT) begin
							res.param_done = PD_VALUE;
							res.tag_done   = fin_tag;
						end else begin
							res.out_byte  = c;
							res.out_class = CL_PVAL;
						end
					end
				end
				ST_DQ, ST_SQ: begin
					if (c == CH_NUL) res.tag_done = TD_ABORT;
					else if (!((st == ST_DQ && c == CH_DQ) || (st == ST_SQ && c == CH_SQ))) begin
						res.out_byte  = c;
						res.out_class = CL_PVAL;
					end
				end
				ST_BARE: begin
					if (c == CH_NUL) res.tag_done = TD_ABORT;
					else if (c == CH_GT) begin
						res.param_done = PD_VALUE;
						res.tag_done   = fin_tag;
					end else if (!is_blank(c)) begin
						res.out_byte  = c;
						res.out_class = CL_PVAL;
					end
				end
				default: ;
			endcase
		end
	end

endmodule

[design/markup_tag_tokenizer.sv]
// Top level of the markup tag tokenizer: input register, parser state and result register.
`timescale 1ns / 1ps
// Latency: a byte accepted into the input register passes through the parser step into the
// result register, which drives the output; a stalled sink holds the result there.
// Throughput: one byte per cycle while the sink keeps taking results; each byte yields exactly one result item.
// The rate is set by the combinational parser step between the input and result registers.
// Reset (arst_n low, asynchronous): both stages empty, parser outside any tag, flags clear.

module markup_tag_tokenizer
	import mtt_pkg::*;
(
	input logic          clk,
	input logic          arst_n,
	mtt_stream_if.sink   byte_ch,
	mtt_stream_if.source token_ch
);

	// Stage 1 holds the accepted byte; stage 2 holds the finished result.
	logic    valid_s1;
	item_t   item_s1;
	logic    valid_s2;
	result_t res_s2;

	parse_t  state_q;
	parse_t  state_nxt;
	result_t res_nxt;

	logic    stall;
	logic    fire_s1;

	// A result waiting on a stalled sink blocks stage 1 from moving on.
	assign stall   = valid_s2 && !token_ch.ready;
	assign fire_s1 = valid_s1 && !stall;

	// Take a new byte whenever stage 1 is empty or drains this cycle.
	assign byte_ch.ready = !valid_s1 || !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (byte_ch.ready) begin
			valid_s1 <= byte_ch.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (byte_ch.ready && byte_ch.valid) begin
			item_s1 <= byte_ch.data;
		end
	end

	mtt_step u_step (
		.cur  (state_q),
		.item (item_s1),
		.nxt  (state_nxt),
		.res  (res_nxt)
	);

	// Advance the parser only when the byte in stage 1 moves to the result stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '{st: ST_OUT, tag_is_end: 1'b0, hyphen_seen: 1'b0};
		end else if (fire_s1) begin
			state_q <= state_nxt;
		end
	end

	// Result stage: load on a fresh result, drop once the sink takes the item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (!stall) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (fire_s1) begin
			res_s2 <= res_nxt;
		end
	end

	assign token_ch.valid = valid_s2;
	assign token_ch.data  = res_s2;

	// A byte that closes or aborts a tag leaves the parser outside any tag.
	a_done_goes_out: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && res_nxt.tag_done != TD_NONE |=> state_q.st == ST_OUT)
		else $error("parser not idle after tag completion");

	// Stream end always returns the parser to its reset state.
	a_end_resets: assert property (@(posedge clk) disable iff (!arst_n)
		fire_s1 && item_s1.stream_end |=>
			state_q.st == ST_OUT && !state_q.tag_is_end && !state_q.hyphen_seen)
		else $error("stream end did not clear parser state");

	// The hyphen mark only lives inside a comment.
	a_hyphen_in_comment: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.hyphen_seen |-> state_q.st == ST_COMMENT)
		else $error("hyphen mark set outside a comment");

	// No character means a zero byte on the output.
	a_none_zero_byte: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.out_class == CL_NONE |-> res_s2.out_byte == 8'h00)
		else $error("byte emitted without a class");

	// A parameter close never shares a result with a tag name character.
	a_param_not_tag: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && res_s2.param_done != PD_NONE |-> res_s2.out_class != CL_TAG)
		else $error("parameter close alongside tag name character");

endmodule
